/* src/bf_pkg.sv */
// ----------------------------------------------------------------------------
// bf_pkg: shared constants for the Blowfish block cipher core
// Round count, subkey store sizes, command codes and derived index widths.
// ----------------------------------------------------------------------------
package bf_pkg;

  // Cipher and subkey store dimensions.
  localparam int ROUNDS  = 16;
  localparam int P_DEPTH = 18;
  localparam int S_DEPTH = 256;
  localparam int S_BOXES = 4;

  // Field widths of one beat.
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int WORD_W  = 32;
  localparam int BLOCK_W = 64;
  localparam int IN_DATA_W  = ((IDX_W + WORD_W + BLOCK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((BLOCK_W + 7) / 8) * 8;

  // Index widths: the key index runs from 0 to ROUNDS+1 and must also reach
  // every P entry so that the store can be addressed with a part-select.
  localparam int KEY_SPAN = (ROUNDS + 2 > P_DEPTH) ? ROUNDS + 2 : P_DEPTH;
  localparam int KEY_W    = $clog2(KEY_SPAN);
  localparam int PIDX_W   = $clog2(P_DEPTH);
  localparam int SADDR_W  = $clog2(S_DEPTH);
  localparam int SBOX_W   = $clog2(S_BOXES);

  // Commands carried on tuser.
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_WR_P = 2'd0;
  localparam cmd_t CMD_WR_S = 2'd1;
  localparam cmd_t CMD_ENC  = 2'd2;
  localparam cmd_t CMD_DEC  = 2'd3;

endpackage

/* src/blowfish_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// blowfish_block_cipher_core: Blowfish encrypt/decrypt engine
//
// The input channel carries one command per beat on in_tuser. A P write or
// S write beat stores table_word at table_index and produces no output beat;
// a P index past the array is dropped. An encrypt or decrypt beat runs block_in
// through the cipher and produces exactly one output beat with the 64-bit result.
//
// Each block passes through a load step that applies the first P whitening
// and issues the first S-box reads, one step per round on the shared
// round-function unit, and a final whitening step. The round rate is set by
// the four synchronous S-box memories, each read once per round.
// The engine stays idle across table writes.
//
// in_tready is high only while the engine is idle. Once the result sits in
// the output register a new beat can be accepted; if a second result is
// ready while the first is still stalled on out_tready, the engine holds
// in its final cycle until the output register frees up.
// After reset the engine is idle with no output pending; P and S contents
// are undefined until software loads them.
// ----------------------------------------------------------------------------
module blowfish_block_cipher_core
  import bf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, from bit 0 up: table_index[9:0], table_word[31:0],
  // block_in[63:0], zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd[1:0].
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata, from bit 0 up: block_out[63:0].
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  round_r, round_nxt;
  logic              dec_r, dec_nxt;
  logic [WORD_W-1:0] left_r, left_nxt;
  logic [WORD_W-1:0] right_r, right_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0] out_data_r, out_data_nxt;

  logic [WORD_W-1:0] p_r [P_DEPTH];
  logic [WORD_W-1:0] s_rd_r [S_BOXES];
  logic [SADDR_W-1:0] s_addr [S_BOXES];

  logic              in_fire;
  cmd_t              in_cmd;
  logic [IDX_W-1:0]  in_index;
  logic [WORD_W-1:0] in_word;
  logic [BLOCK_W-1:0] in_block;
  logic              out_free;

  logic              key_dec;
  logic [KEY_W-1:0]  key_k;
  logic [KEY_W-1:0]  key_idx;
  logic [WORD_W-1:0] key_word;
  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] load_left;
  logic [WORD_W-1:0] addr_src;

  // Beat unpacking.
  assign in_cmd   = in_tuser;
  assign in_index = in_tdata[IDX_W-1:0];
  assign in_word  = in_tdata[IDX_W+WORD_W-1:IDX_W];
  assign in_block = in_tdata[IDX_W+WORD_W+BLOCK_W-1:IDX_W+WORD_W];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_free   = !out_valid_r || out_tready;

  // Subkey selection: one P read per cycle, reversed order for decryption.
  always_comb begin
    key_dec = (state_r == ST_IDLE) ? (in_cmd == CMD_DEC) : dec_r;
    unique case (state_r)
      ST_IDLE: key_k = '0;
      ST_RUN:  key_k = round_r;
      ST_FIN:  key_k = KEY_W'(ROUNDS + 1);
      default: key_k = '0;
    endcase
    key_idx = key_dec ? (KEY_W'(ROUNDS + 1) - key_k) : key_k;
    if (key_idx < KEY_W'(P_DEPTH)) begin
      key_word = p_r[key_idx[PIDX_W-1:0]];
    end else begin
      key_word = '0;
    end
  end

  // Shared round-function unit fed by the registered S-box reads.
  assign f_val     = ((s_rd_r[0] + s_rd_r[1]) ^ s_rd_r[2]) + s_rd_r[3];
  assign mix       = right_r ^ f_val ^ key_word;
  assign load_left = in_block[BLOCK_W-1:WORD_W] ^ key_word;

  // S-box read addresses come from the left half entering the next round.
  always_comb begin
    unique case (state_r)
      ST_IDLE: addr_src = load_left;
      ST_RUN:  addr_src = mix;
      default: addr_src = left_r;
    endcase
    for (int b = 0; b < S_BOXES; b++) begin
      s_addr[b] = addr_src[WORD_W-1-8*b -: SADDR_W];
    end
  end

  // Four S-box memories, one per box, each read once per cycle.
  for (genvar g = 0; g < S_BOXES; g++) begin : g_sbox
    logic [WORD_W-1:0] mem [S_DEPTH];
    always_ff @(posedge clk) begin
      if (in_fire && (in_cmd == CMD_WR_S) &&
          (in_index[IDX_W-1:SADDR_W] == SBOX_W'(g))) begin
        mem[in_index[SADDR_W-1:0]] <= in_word;
      end
      s_rd_r[g] <= mem[s_addr[g]];
    end
  end

  // P-array store.
  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_WR_P) && (in_index < IDX_W'(P_DEPTH))) begin
      p_r[in_index[PIDX_W-1:0]] <= in_word;
    end
  end

  // Sequencer: load, ROUNDS rounds, final whitening.
  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    dec_nxt       = dec_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && ((in_cmd == CMD_ENC) || (in_cmd == CMD_DEC))) begin
          state_nxt = ST_RUN;
          round_nxt = KEY_W'(1);
          dec_nxt   = (in_cmd == CMD_DEC);
          left_nxt  = load_left;
          right_nxt = in_block[WORD_W-1:0];
        end
      end
      ST_RUN: begin
        left_nxt  = mix;
        right_nxt = left_r;
        round_nxt = round_r + KEY_W'(1);
        if (round_r == KEY_W'(ROUNDS)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // The last swap is undone: result is {right ^ P, left}.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {right_r ^ key_word, left_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    round_r    <= round_nxt;
    dec_r      <= dec_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* sim/blowfish_block_cipher_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blowfish_block_cipher_core_tb: self-checking bench for the Blowfish core
// Loads the whole P-array and all four S-boxes, then runs directed and random
// beats: table writes, out-of-range P writes, single blocks and encrypt and
// decrypt round trips. A predictor tracks the subkey store as beats are
// accepted and checks every output block in order. Both channels stall at
// random.
// ----------------------------------------------------------------------------
module blowfish_block_cipher_core_tb;
  import bf_pkg::*;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BLOCK_W-1:0] block_t;

  typedef struct {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    word_t            word;
    block_t           blk;
    bit               drain;
  } bf_beat_t;

  localparam int RAND_BEATS  = 690;
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;

  // Beats waiting to be sent and blocks waiting to come back.
  bf_beat_t beat_q[$];
  block_t   block_out_q[$];

  // Subkey store as seen by the stimulus generator and by the checker.
  word_t plan_p [P_DEPTH];
  word_t plan_s [S_BOXES*S_DEPTH];
  word_t key_p  [P_DEPTH];
  word_t key_s  [S_BOXES*S_DEPTH];

  int items_total = 0;
  int blocks_total = 0;
  int beats_in = 0;
  int blocks_done = 0;
  int blocks_sent = 0;
  int cycles = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;
  bit failed = 1'b0;

  blowfish_block_cipher_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // P word for whitening step k; decryption walks the P-array backwards and
  // an index past the end of the store reads as zero.
  function automatic word_t sub_key(input int k, input bit dec,
                                    input word_t pw [P_DEPTH]);
    int i;
    i = dec ? ROUNDS + 1 - k : k;
    if (i < P_DEPTH) return pw[i];
    return '0;
  endfunction

  // Full Feistel pass over one block with the given subkey store.
  function automatic block_t bf_cipher(input block_t blk, input bit dec,
                                       input word_t pw [P_DEPTH],
                                       input word_t sw [S_BOXES*S_DEPTH]);
    word_t lh, rh, tmp, f;
    int r;
    lh = blk[63:32];
    rh = blk[31:0];
    lh = lh ^ sub_key(0, dec, pw);
    for (r = 1; r <= ROUNDS; r++) begin
      f = ((sw[lh[31:24]] + sw[S_DEPTH + lh[23:16]]) ^ sw[2*S_DEPTH + lh[15:8]])
          + sw[3*S_DEPTH + lh[7:0]];
      rh = rh ^ f ^ sub_key(r, dec, pw);
      tmp = lh;
      lh = rh;
      rh = tmp;
    end
    rh = rh ^ sub_key(ROUNDS + 1, dec, pw);
    return {rh, lh};
  endfunction

  // Idle length: mostly none or short, now and then long, with calm stretches.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Queue one beat and keep the generator's copy of the store up to date.
  task automatic add_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                          input word_t word, input block_t blk, input bit drain);
    bf_beat_t b;
    b.cmd = cmd;
    b.idx = idx;
    b.word = word;
    b.blk = blk;
    b.drain = drain;
    beat_q.insert(beat_q.size(), b);
    items_total++;
    case (cmd)
      CMD_WR_P: if (idx < P_DEPTH) plan_p[idx] = word;
      CMD_WR_S: plan_s[idx] = word;
      default:  blocks_total++;
    endcase
  endtask

  // Encrypt then decrypt (or the other way round) so the pair undoes itself.
  task automatic add_round_trip(input block_t blk, input bit dec_first,
                                input bit drain);
    block_t mid;
    add_item(dec_first ? CMD_DEC : CMD_ENC, IDX_W'($urandom), $urandom, blk, drain);
    mid = bf_cipher(blk, dec_first, plan_p, plan_s);
    add_item(dec_first ? CMD_ENC : CMD_DEC, IDX_W'($urandom), $urandom, mid, 1'b0);
  endtask

  // Stimulus plan, reset and end of run.
  initial begin
    int i, pick, rand_start;
    bit mid_drain;
    rst_n = 1'b0;
    mid_drain = 1'b0;

    // Load the whole store so no block ever reads an unwritten entry.
    for (i = 0; i < P_DEPTH; i++)
      add_item(CMD_WR_P, IDX_W'(i), $urandom, {$urandom, $urandom}, 1'b0);
    for (i = 0; i < S_BOXES*S_DEPTH; i++)
      add_item(CMD_WR_S, IDX_W'(i), $urandom, {$urandom, $urandom}, 1'b0);

    // Directed beats: extreme blocks, ignored fields and out-of-range P writes.
    add_item(CMD_ENC, '0, '0, '0, 1'b0);
    add_item(CMD_ENC, '1, '1, '1, 1'b0);
    add_item(CMD_DEC, '0, '0, '0, 1'b0);
    add_item(CMD_DEC, '1, '1, '1, 1'b0);
    add_item(CMD_WR_P, IDX_W'(P_DEPTH), '1, '1, 1'b0);
    add_item(CMD_WR_P, '1, '0, '0, 1'b0);
    add_item(CMD_ENC, '0, '0, 64'h0123_4567_89AB_CDEF, 1'b1);
    add_item(CMD_WR_P, '0, '1, '0, 1'b0);
    add_item(CMD_WR_P, IDX_W'(P_DEPTH - 1), '0, '1, 1'b0);
    add_item(CMD_WR_S, '0, '0, '1, 1'b0);
    add_item(CMD_WR_S, '1, '1, '0, 1'b0);
    add_item(CMD_WR_S, IDX_W'(S_DEPTH), 32'h8000_0001, '0, 1'b0);
    add_round_trip('1, 1'b0, 1'b0);
    add_round_trip('0, 1'b1, 1'b0);
    add_item(CMD_DEC, '0, '1, 64'hFEDC_BA98_7654_3210, 1'b0);
    add_item(CMD_ENC, '1, '0, 64'h8000_0000_0000_0001, 1'b0);

    // Random beats: mostly blocks and round trips, with table rewrites.
    rand_start = items_total;
    while (items_total < rand_start + RAND_BEATS) begin
      pick = $urandom_range(0, 99);
      if (!mid_drain && items_total >= rand_start + RAND_BEATS / 2) begin
        mid_drain = 1'b1;
        add_round_trip({$urandom, $urandom}, $urandom_range(0, 1), 1'b1);
      end else if (pick < 10) begin
        add_item(CMD_WR_P,
                 ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                                              : IDX_W'($urandom_range(0, P_DEPTH - 1)),
                 $urandom, {$urandom, $urandom}, $urandom_range(0, 249) == 0);
      end else if (pick < 30) begin
        add_item(CMD_WR_S, IDX_W'($urandom), $urandom, {$urandom, $urandom},
                 $urandom_range(0, 249) == 0);
      end else if (pick < 50) begin
        add_round_trip({$urandom, $urandom}, $urandom_range(0, 1),
                       $urandom_range(0, 249) == 0);
      end else begin
        add_item(($urandom_range(0, 1) == 1) ? CMD_DEC : CMD_ENC, IDX_W'($urandom),
                 $urandom, {$urandom, $urandom}, $urandom_range(0, 249) == 0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be taken and every block to come back.
    while (beats_in != items_total || blocks_done != blocks_total)
      @(posedge clk);
    repeat (ROUNDS + 8) @(posedge clk);

    if (block_out_q.size() != 0)
      $error("%0d expected blocks never arrived", block_out_q.size());
    if (!failed && block_out_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Input driver: presents queued beats, idles between them and holds a beat
  // back until all blocks in flight have returned when it asks for that.
  always @(posedge clk) begin : drive_beats
    bf_beat_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= CMD_WR_P;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready && (in_tuser == CMD_ENC || in_tuser == CMD_DEC))
        blocks_sent++;
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (beat_q.size() != 0 &&
                     !(beat_q[0].drain && blocks_sent != blocks_done)) begin
          nxt = beat_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.cmd;
          in_tdata <= IN_DATA_W'({nxt.blk, nxt.word, nxt.idx});
          in_gap = next_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: tracks the store on accepted input beats, predicts each block
  // and checks output beats in order; also stalls the output at random.
  always @(posedge clk) begin : watch_beats
    logic [IDX_W-1:0] idx;
    word_t            word;
    block_t           want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        idx  = in_tdata[IDX_W-1:0];
        word = in_tdata[IDX_W +: WORD_W];
        case (in_tuser)
          CMD_WR_P: if (idx < P_DEPTH) key_p[idx] = word;
          CMD_WR_S: key_s[idx] = word;
          default:
            block_out_q.insert(block_out_q.size(),
                               bf_cipher(in_tdata[IDX_W+WORD_W +: BLOCK_W],
                                         in_tuser == CMD_DEC, key_p, key_s));
        endcase
        beats_in <= beats_in + 1;
      end

      if (out_tvalid && out_tready) begin
        if (block_out_q.size() == 0) begin
          $error("block_out %h arrived with no block expected", out_tdata[BLOCK_W-1:0]);
          failed = 1'b1;
        end else begin
          want = block_out_q.pop_front();
          if (out_tdata[BLOCK_W-1:0] !== want) begin
            $error("block_out mismatch: expected %h, actual %h",
                   want, out_tdata[BLOCK_W-1:0]);
            failed = 1'b1;
          end
        end
        blocks_done <= blocks_done + 1;
      end

      if (out_hold == 0 && $urandom_range(0, 3) == 0)
        out_hold = next_gap(out_calm);
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
